>>> rtl/date_add_and_difference_assert.svh
// Concurrent assertion macros for the date add and difference block.
// Depends on nothing; included by the top level, which holds the assertions.
`ifndef DATE_ADD_AND_DIFFERENCE_ASSERT_SVH
`define DATE_ADD_AND_DIFFERENCE_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define DAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("date_add_and_difference: same-cycle check failed");
// Antecedent implies consequent in the following cycle.
`define DAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("date_add_and_difference: next-cycle check failed");
`else
`define DAD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DAD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/dad_pkg.sv
// Shared types, constants and calendar tables for the date add and difference block.
// Depends on nothing; used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
package dad_pkg;

	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned ADD_W    = 16;
	localparam int unsigned LEFT_W   = 17;
	localparam int unsigned DIFF_W   = 21;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned YLEN_W   = 9;

	localparam logic [DIFF_W-1:0]  DIFF_MAX   = 21'd2097151;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [YLEN_W-1:0]  YEAR_LEN   = 9'd365;
	localparam logic [YLEN_W-1:0]  LEAP_LEN   = 9'd366;
	localparam logic [DAY_W-1:0]   FEB_LEAP   = 5'd29;
	localparam logic [DAY_W-1:0]   FEB_COMMON = 5'd28;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_LATER    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_DN_A,
		S_DN_B,
		S_DN_C,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    step;
		logic    mul_en;
		logic    mul_sel_b;
		logic    na_en;
		logic    nb_en;
		logic    set_res;
		status_t res_st;
	} dad_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic func;
		logic valid_a;
		logic valid_b;
		logic fits;
		logic ovf;
	} dad_sts_t;

	// Length of a month; zero for a month code outside 1 to 12.
	function automatic logic [DAY_W-1:0] month_days(input logic leap,
			input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:    len = leap ? FEB_LEAP : FEB_COMMON;
			default: len = '0;
		endcase
		return len;
	endfunction

	// Days in the common year before the first of a month.
	function automatic logic [YLEN_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [YLEN_W-1:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/dad_in_if.sv
// Request channel of the date add and difference block: valid, ready and the request fields.
// Depends on dad_pkg for the fixed field widths.
`timescale 1ns / 1ps
interface dad_in_if #(
	parameter int unsigned YEAR_BITS = 12
);
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [YEAR_BITS-1:0]          year_a;
	logic [dad_pkg::MONTH_W-1:0]   month_a;
	logic [dad_pkg::DAY_W-1:0]     day_a;
	logic [dad_pkg::ADD_W-1:0]     days_to_add;
	logic [YEAR_BITS-1:0]          year_b;
	logic [dad_pkg::MONTH_W-1:0]   month_b;
	logic [dad_pkg::DAY_W-1:0]     day_b;

	modport source (output valid, func, year_a, month_a, day_a, days_to_add,
		year_b, month_b, day_b, input ready);
	modport sink (input valid, func, year_a, month_a, day_a, days_to_add,
		year_b, month_b, day_b, output ready);
endinterface

>>> rtl/dad_out_if.sv
// Result channel of the date add and difference block: valid, ready and the result fields.
// Depends on dad_pkg for the fixed field widths.
`timescale 1ns / 1ps
interface dad_out_if #(
	parameter int unsigned YEAR_BITS = 12
);
	logic                          valid;
	logic                          ready;
	logic [YEAR_BITS-1:0]          res_year;
	logic [dad_pkg::MONTH_W-1:0]   res_month;
	logic [dad_pkg::DAY_W-1:0]     res_day;
	logic [dad_pkg::DIFF_W-1:0]    day_difference;
	logic [dad_pkg::STATUS_W-1:0]  status;

	modport source (output valid, res_year, res_month, res_day, day_difference, status,
		input ready);
	modport sink (input valid, res_year, res_month, res_day, day_difference, status,
		output ready);
endinterface

>>> rtl/date_add_and_difference.sv
// Top level of the date add and difference block: controller, datapath and assertions.
// Depends on dad_pkg, dad_in_if, dad_out_if, dad_ctrl, dad_dp and the assertion header.
//
//   Channel   Direction  Carries
//   in_ch     sink       func, year_a, month_a, day_a, days_to_add, year_b, month_b, day_b
//   out_ch    source     res_year, res_month, res_day, day_difference, status
//
// One request is in work at a time. A difference passes the check, the day-number states
// S_DN_A, S_DN_B and S_DN_C and the hand-over, using the shared year-times-365 multiplier
// once per date. An add walks forward after the check: a whole year per step while the walk
// stands in January with more days left than the year holds, else a month.
// Reset clears the controller and the result valid flag. A finished result waits in the output
// register while the next request is taken; that one waits in S_FIN until the first has gone.
`timescale 1ns / 1ps
`include "date_add_and_difference_assert.svh"
module date_add_and_difference #(
	parameter int unsigned YEAR_BITS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	dad_in_if.sink    in_ch,
	dad_out_if.source out_ch
);
	import dad_pkg::*;

	// Command and status bundles between the controller and the datapath.
	dad_cmd_t cmd;
	dad_sts_t sts;

	// The controller sequences each request: validity check, then either the month walk
	// of an add or the day-number evaluation of a difference, and finally
	// the hand-over into the result register once that register is free.
	dad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the captured request, the running year, month and day count,
	// the day numbers of both dates and the result register that drives the output.
	dad_dp #(
		.YEAR_BITS (YEAR_BITS)
	) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.sts            (sts),
		.func           (in_ch.func),
		.year_a         (in_ch.year_a),
		.month_a        (in_ch.month_a),
		.day_a          (in_ch.day_a),
		.days_to_add    (in_ch.days_to_add),
		.year_b         (in_ch.year_b),
		.month_b        (in_ch.month_b),
		.day_b          (in_ch.day_b),
		.res_year       (out_ch.res_year),
		.res_month      (out_ch.res_month),
		.res_day        (out_ch.res_day),
		.day_difference (out_ch.day_difference),
		.status         (out_ch.status)
	);

	// A new result is only written when the previous one has gone or is leaving.
	`DAD_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.set_res, !out_ch.valid || out_ch.ready)
	// The walk never steps past a day count that already fits its month.
	`DAD_ASSERT_IMP(a_step_needs_room, clk, arst_n, cmd.step, !sts.fits)
	// After a request is taken the block works on it before taking another.
	`DAD_ASSERT_NXT(a_one_in_work, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	// Any status but success leaves the date fields of the result clear.
	`DAD_ASSERT_IMP(a_err_clears_date, clk, arst_n, out_ch.valid && (out_ch.status != ST_OK), out_ch.res_month == '0)

endmodule

>>> rtl/dad_ctrl.sv
// Controller state machine of the date add and difference block.
// Depends on dad_pkg for the state, command and status types.
`timescale 1ns / 1ps
module dad_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dad_pkg::dad_sts_t sts,
	output dad_pkg::dad_cmd_t cmd
);
	import dad_pkg::*;

	state_t  state_q, state_d;
	status_t st_q, st_d;
	logic    out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.set_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		st_d     = st_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.valid_a || (sts.func && !sts.valid_b)) begin
					st_d    = ST_INVALID;
					state_d = S_FIN;
				end else if (sts.func) begin
					state_d = S_DN_A;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				priority if (sts.fits) begin
					st_d    = ST_OK;
					state_d = S_FIN;
				end else if (sts.ovf) begin
					st_d    = ST_OVERFLOW;
					state_d = S_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_DN_A: begin
				cmd.mul_en = 1'b1;
				state_d    = S_DN_B;
			end
			S_DN_B: begin
				cmd.na_en     = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel_b = 1'b1;
				state_d       = S_DN_C;
			end
			S_DN_C: begin
				cmd.nb_en = 1'b1;
				st_d      = ST_OK;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.set_res = 1'b1;
					cmd.res_st  = st_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/dad_dp.sv
// Datapath of the date add and difference block: operand registers, month walker,
// day-number unit and result register. Depends on dad_pkg.
`timescale 1ns / 1ps
module dad_dp #(
	parameter int unsigned YEAR_BITS = 12
) (
	input  logic                           clk,
	input  dad_pkg::dad_cmd_t              cmd,
	output dad_pkg::dad_sts_t              sts,
	input  logic                           func,
	input  logic [YEAR_BITS-1:0]           year_a,
	input  logic [dad_pkg::MONTH_W-1:0]    month_a,
	input  logic [dad_pkg::DAY_W-1:0]      day_a,
	input  logic [dad_pkg::ADD_W-1:0]      days_to_add,
	input  logic [YEAR_BITS-1:0]           year_b,
	input  logic [dad_pkg::MONTH_W-1:0]    month_b,
	input  logic [dad_pkg::DAY_W-1:0]      day_b,
	output logic [YEAR_BITS-1:0]           res_year,
	output logic [dad_pkg::MONTH_W-1:0]    res_month,
	output logic [dad_pkg::DAY_W-1:0]      res_day,
	output logic [dad_pkg::DIFF_W-1:0]     day_difference,
	output logic [dad_pkg::STATUS_W-1:0]   status
);
	import dad_pkg::*;

	// Day numbers stay below 366 times the year span.
	localparam int unsigned DN_W  = YEAR_BITS + 9;
	localparam int unsigned EXT_W = (DN_W > DIFF_W) ? DN_W : DIFF_W;

	logic                 func_q;
	logic [YEAR_BITS-1:0] ya_q, yb_q, y_q;
	logic [MONTH_W-1:0]   ma_q, mb_q, m_q;
	logic [DAY_W-1:0]     da_q, db_q;
	logic [LEFT_W-1:0]    left_q;
	logic [DN_W-1:0]      mul_q, off_q, na_q, nb_q;

	logic [YEAR_BITS-1:0] res_year_q;
	logic [MONTH_W-1:0]   res_month_q;
	logic [DAY_W-1:0]     res_day_q;
	logic [DIFF_W-1:0]    diff_q;
	status_t              status_q;

	// Walk decode.
	logic              leap, y_max, yskip;
	logic [DAY_W-1:0]  dim;
	logic [YLEN_W-1:0] ylen;

	// Day-number operand selection.
	logic [YEAR_BITS-1:0] ysel;
	logic [MONTH_W-1:0]   msel;
	logic [DAY_W-1:0]     dsel;
	logic [YEAR_BITS:0]   yplus3;
	logic [DN_W-1:0]      off_sel;
	logic                 sel_leap;

	logic [DN_W-1:0]  dd;
	logic [EXT_W-1:0] dd_ext;

	assign leap  = (y_q[1:0] == 2'b00);
	assign dim   = month_days(leap, m_q);
	assign ylen  = leap ? LEAP_LEN : YEAR_LEN;
	assign y_max = (y_q == {YEAR_BITS{1'b1}});
	assign yskip = (m_q == MONTH_JAN) && (left_q > LEFT_W'(ylen));

	assign sts.func    = func_q;
	assign sts.valid_a = (da_q != '0) && (da_q <= month_days(ya_q[1:0] == 2'b00, ma_q));
	assign sts.valid_b = (db_q != '0) && (db_q <= month_days(yb_q[1:0] == 2'b00, mb_q));
	assign sts.fits    = (left_q <= LEFT_W'(dim));
	assign sts.ovf     = y_max && (yskip || (m_q == MONTH_DEC));

	assign ysel     = cmd.mul_sel_b ? yb_q : ya_q;
	assign msel     = cmd.mul_sel_b ? mb_q : ma_q;
	assign dsel     = cmd.mul_sel_b ? db_q : da_q;
	assign sel_leap = (ysel[1:0] == 2'b00) && (msel > MONTH_FEB);
	assign yplus3   = {1'b0, ysel} + (YEAR_BITS+1)'(3);
	assign off_sel  = DN_W'(yplus3 >> 2) + DN_W'(days_before(msel))
		+ DN_W'(sel_leap) + DN_W'(dsel);

	assign dd     = na_q - nb_q;
	assign dd_ext = EXT_W'(dd);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			ya_q   <= year_a;
			ma_q   <= month_a;
			da_q   <= day_a;
			yb_q   <= year_b;
			mb_q   <= month_b;
			db_q   <= day_b;
			y_q    <= year_a;
			m_q    <= month_a;
			left_q <= LEFT_W'(days_to_add) + LEFT_W'(day_a);
		end else if (cmd.step) begin
			if (yskip) begin
				y_q    <= y_q + YEAR_BITS'(1);
				left_q <= left_q - LEFT_W'(ylen);
			end else begin
				left_q <= left_q - LEFT_W'(dim);
				if (m_q == MONTH_DEC) begin
					m_q <= MONTH_JAN;
					y_q <= y_q + YEAR_BITS'(1);
				end else begin
					m_q <= m_q + MONTH_W'(1);
				end
			end
		end

		if (cmd.mul_en) begin
			mul_q <= DN_W'(ysel) * DN_W'(YEAR_LEN);
			off_q <= off_sel;
		end
		if (cmd.na_en) begin
			na_q <= mul_q + off_q;
		end
		if (cmd.nb_en) begin
			nb_q <= mul_q + off_q;
		end

		if (cmd.set_res) begin
			res_year_q  <= '0;
			res_month_q <= '0;
			res_day_q   <= '0;
			diff_q      <= '0;
			status_q    <= cmd.res_st;
			if (cmd.res_st == ST_OK) begin
				if (!func_q) begin
					res_year_q  <= y_q;
					res_month_q <= m_q;
					res_day_q   <= left_q[DAY_W-1:0];
				end else if (nb_q > na_q) begin
					status_q <= ST_LATER;
				end else begin
					diff_q <= (dd_ext > EXT_W'(DIFF_MAX)) ? DIFF_MAX : dd_ext[DIFF_W-1:0];
				end
			end
		end
	end

	assign res_year       = res_year_q;
	assign res_month      = res_month_q;
	assign res_day        = res_day_q;
	assign day_difference = diff_q;
	assign status         = status_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for date_add_and_difference: directed calendar corners, then random
// adds and differences under random back-pressure, each result checked by a model in the bench.
// Depends on dad_pkg, dad_in_if, dad_out_if and the date_add_and_difference top level.
module tb;
	import dad_pkg::*;

	localparam int unsigned YEAR_BITS      = 12;
	localparam int unsigned YEAR_TOP       = (1 << YEAR_BITS) - 1;
	localparam int unsigned MONTHS         = 12;
	localparam logic        OP_ADD         = 1'b0;
	localparam logic        OP_DIFF        = 1'b1;
	localparam int unsigned HALF_PERIOD    = 10;
	localparam int unsigned RESET_CYCLES   = 8;
	localparam int unsigned CHUNK          = 50;
	localparam int unsigned LONG_HOLD      = 400;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES    = 250;

	// One request as it crosses the input channel, fields in port order.
	typedef struct packed {
		logic                 func;
		logic [YEAR_BITS-1:0] year_a;
		logic [MONTH_W-1:0]   month_a;
		logic [DAY_W-1:0]     day_a;
		logic [ADD_W-1:0]     days_to_add;
		logic [YEAR_BITS-1:0] year_b;
		logic [MONTH_W-1:0]   month_b;
		logic [DAY_W-1:0]     day_b;
	} request_t;

	// One result as it leaves the output channel.
	typedef struct packed {
		logic [YEAR_BITS-1:0] res_year;
		logic [MONTH_W-1:0]   res_month;
		logic [DAY_W-1:0]     res_day;
		logic [DIFF_W-1:0]    day_difference;
		logic [STATUS_W-1:0]  status;
	} result_t;

	// Works out the result of every accepted request and compares the block's results with
	// those, oldest first.
	class date_checker;
		result_t     results_due[$];
		int unsigned mismatches;
		int unsigned adds;
		int unsigned diffs;
		int unsigned status_seen[4];

		// Every fourth year is a leap year, with no exception for centuries. A month code
		// outside the calendar has no days at all, which makes any date in it invalid.
		function int unsigned month_length(int unsigned y, int unsigned m);
			case (m)
				1, 3, 5, 7, 8, 10, 12: return 31;
				4, 6, 9, 11:           return 30;
				2:                     return (y % 4 == 0) ? 29 : 28;
				default:               return 0;
			endcase
		endfunction

		function bit date_ok(int unsigned y, int unsigned m, int unsigned d);
			return d >= 1 && d <= month_length(y, m);
		endfunction

		// Days since the start of year 0, with 1 January of year 0 as day 1.
		function int unsigned day_count(int unsigned y, int unsigned m, int unsigned d);
			int unsigned n;
			n = y * 365 + (y + 3) / 4 + d;
			for (int unsigned k = 1; k < m; k++)
				n += month_length(y, k);
			return n;
		endfunction

		function result_t calendar_result(request_t r);
			result_t     res;
			int unsigned left;
			int unsigned y;
			int unsigned m;
			int unsigned na;
			int unsigned nb;
			bit          carried_out;
			res = '0;
			res.status = ST_OK;
			if (r.func == OP_ADD) begin
				if (!date_ok(r.year_a, r.month_a, r.day_a)) begin
					res.status = ST_INVALID;
				end else begin
					// Walk forward a month at a time until the remaining count fits.
					left = r.days_to_add + r.day_a;
					y = r.year_a;
					m = r.month_a;
					carried_out = 1'b0;
					while (!carried_out && left > month_length(y, m)) begin
						left -= month_length(y, m);
						m++;
						if (m > MONTHS) begin
							m = 1;
							if (y >= YEAR_TOP)
								carried_out = 1'b1;
							else
								y++;
						end
					end
					if (carried_out) begin
						res.status = ST_OVERFLOW;
					end else begin
						res.res_year = YEAR_BITS'(y);
						res.res_month = MONTH_W'(m);
						res.res_day = DAY_W'(left);
					end
				end
			end else begin
				if (!date_ok(r.year_a, r.month_a, r.day_a) ||
						!date_ok(r.year_b, r.month_b, r.day_b)) begin
					res.status = ST_INVALID;
				end else begin
					na = day_count(r.year_a, r.month_a, r.day_a);
					nb = day_count(r.year_b, r.month_b, r.day_b);
					if (nb > na)
						res.status = ST_LATER;
					else
						res.day_difference = (na - nb > DIFF_MAX) ? DIFF_MAX
							: DIFF_W'(na - nb);
				end
			end
			return res;
		endfunction

		function void note_request(request_t r);
			result_t due;
			due = calendar_result(r);
			results_due.push_back(due);
			if (r.func == OP_ADD)
				adds++;
			else
				diffs++;
			status_seen[due.status]++;
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] seen);
			mismatches++;
			$error("%s: expected %0d, got %0d", field, want, seen);
		endfunction

		function void check_result(result_t got);
			result_t due;
			if (results_due.size() == 0) begin
				mismatches++;
				$error("result with no request outstanding, status %0d", got.status);
				return;
			end
			due = results_due.pop_front();
			if (got.res_year !== due.res_year)
				report("res_year", due.res_year, got.res_year);
			if (got.res_month !== due.res_month)
				report("res_month", due.res_month, got.res_month);
			if (got.res_day !== due.res_day)
				report("res_day", due.res_day, got.res_day);
			if (got.day_difference !== due.day_difference)
				report("day_difference", due.day_difference, got.day_difference);
			if (got.status !== due.status)
				report("status", due.status, got.status);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	// Set by the sender to ask the receiver for one long hold; cleared when it starts.
	logic        hold_request = 1'b0;
	// The closing stretch of the run, in which neither side idles.
	logic        final_stretch = 1'b0;
	// The sender leaves a gap before one request in this many; zero means no gaps.
	int unsigned sender_odds = 0;
	int unsigned holds_done = 0;
	int unsigned drains_done = 0;
	date_checker ledger = new();

	dad_in_if  #(.YEAR_BITS(YEAR_BITS)) req_ch ();
	dad_out_if #(.YEAR_BITS(YEAR_BITS)) res_ch ();

	date_add_and_difference #(.YEAR_BITS(YEAR_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(req_ch),
		.out_ch(res_ch)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Both channels are sampled at the rising edge. The bench only ever changes its own
	// signals at the falling edge, so everything read here is settled.
	always @(posedge clk) begin : watch_channels
		if (arst_n && req_ch.valid && req_ch.ready)
			ledger.note_request({req_ch.func, req_ch.year_a, req_ch.month_a, req_ch.day_a,
				req_ch.days_to_add, req_ch.year_b, req_ch.month_b, req_ch.day_b});
		if (arst_n && res_ch.valid && res_ch.ready)
			ledger.check_result({res_ch.res_year, res_ch.res_month, res_ch.res_day,
				res_ch.day_difference, res_ch.status});
	end

	// Builds a request from plain numbers; the directed part reads more easily this way.
	function automatic request_t make_request(input logic op, input int unsigned ya, ma, da,
			add, yb, mb, db);
		request_t r;
		r.func = op;
		r.year_a = YEAR_BITS'(ya);
		r.month_a = MONTH_W'(ma);
		r.day_a = DAY_W'(da);
		r.days_to_add = ADD_W'(add);
		r.year_b = YEAR_BITS'(yb);
		r.month_b = MONTH_W'(mb);
		r.day_b = DAY_W'(db);
		return r;
	endfunction

	// Most random requests carry well-formed dates, so that the walk and the day count are
	// exercised over the whole year range. One in ten keeps raw field bits, which mostly
	// gives invalid months and days. Fields that an operation ignores stay random.
	function automatic request_t random_request();
		request_t    r;
		logic [63:0] raw;
		int unsigned y;
		int unsigned m;
		int unsigned choice;
		raw = {$urandom, $urandom};
		r = raw[$bits(request_t)-1:0];
		r.func = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0)
			return r;
		// Date A, now and then close to the top of the year range so that adds overflow.
		y = ($urandom_range(0, 9) == 0) ? $urandom_range(YEAR_TOP - 200, YEAR_TOP)
			: $urandom_range(0, YEAR_TOP);
		m = $urandom_range(1, MONTHS);
		r.year_a = YEAR_BITS'(y);
		r.month_a = MONTH_W'(m);
		// The last day of the month, leap days among them, gets a fair share.
		r.day_a = DAY_W'(($urandom_range(0, 9) == 0) ? ledger.month_length(y, m)
			: $urandom_range(1, ledger.month_length(y, m)));
		case ($urandom_range(0, 3))
			0, 1:    r.days_to_add = ADD_W'($urandom_range(0, 400));
			2:       r.days_to_add = ADD_W'($urandom_range(0, 4000));
			default: ;
		endcase
		if (r.func == OP_DIFF) begin
			choice = $urandom_range(0, 6);
			m = $urandom_range(1, MONTHS);
			case (choice)
				0:       begin y = r.year_a; m = r.month_a; end
				1:       y = $urandom_range(0, YEAR_TOP);
				2:       y = r.year_a;
				default: y = $urandom_range(0, r.year_a);
			endcase
			r.year_b = YEAR_BITS'(y);
			r.month_b = MONTH_W'(m);
			r.day_b = (choice == 0) ? r.day_a
				: DAY_W'($urandom_range(1, ledger.month_length(y, m)));
		end
		return r;
	endfunction

	// Offers one request and returns at the rising edge that accepts it. A random gap may
	// come first; valid stays high from one request to the next when there is none.
	task automatic send_request(input request_t r);
		int unsigned gap;
		gap = 0;
		if (!final_stretch && sender_odds != 0 && $urandom_range(0, sender_odds - 1) == 0)
			gap = $urandom_range(1, 6);
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		{req_ch.func, req_ch.year_a, req_ch.month_a, req_ch.day_a, req_ch.days_to_add,
			req_ch.year_b, req_ch.month_b, req_ch.day_b} = r;
		req_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Stops offering and waits until every result owed has come back.
	task automatic await_all_results();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (ledger.results_due.size() != 0)
			@(posedge clk);
		drains_done++;
	endtask

	task automatic send_random_chunks(input int unsigned chunks);
		repeat (chunks) begin
			// Each chunk has its own gap rate, so calm stretches alternate with busy ones.
			case ($urandom_range(0, 2))
				0:       sender_odds = 0;
				1:       sender_odds = 3;
				default: sender_odds = 10;
			endcase
			repeat (CHUNK)
				send_request(random_request());
		end
	endtask

	// The receiver decides ready afresh at each falling edge: a long hold when the sender
	// asks for one, otherwise random stalls of random length whose rate is redrawn at regular
	// intervals, and none at all in the closing stretch.
	initial begin : receiver
		int unsigned hold_left;
		int unsigned stall_left;
		int unsigned odds;
		int unsigned cycle_count;
		hold_left = 0;
		stall_left = 0;
		odds = 4;
		cycle_count = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cycle_count++;
			if (cycle_count % 64 == 0) begin
				case ($urandom_range(0, 2))
					0:       odds = 0;
					1:       odds = 3;
					default: odds = 10;
				endcase
			end
			if (hold_request) begin
				hold_left = LONG_HOLD;
				hold_request = 1'b0;
				holds_done++;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res_ch.ready = 1'b0;
			end else if (!final_stretch && odds != 0 && $urandom_range(0, odds - 1) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				res_ch.ready = 1'b0;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	// Ends the run if neither channel moves for far longer than the slowest correct request
	// could take, including the long receiver hold.
	initial begin : watchdog
		int unsigned still_cycles;
		still_cycles = 0;
		while (still_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				still_cycles = 0;
			else
				still_cycles++;
		end
		$error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
		$display("date_add_and_difference regression: fail");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		{req_ch.func, req_ch.year_a, req_ch.month_a, req_ch.day_a, req_ch.days_to_add,
			req_ch.year_b, req_ch.month_b, req_ch.day_b} = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, with random stalls on the receiver only.
		// Adds: zero and largest day counts, the last date that exists, year overflow.
		send_request(make_request(OP_ADD, 2000, 1, 1, 0, 0, 1, 1));
		send_request(make_request(OP_ADD, 0, 1, 1, 65535, 4095, 15, 31));
		send_request(make_request(OP_ADD, 4095, 12, 31, 0, 0, 0, 0));
		send_request(make_request(OP_ADD, 4095, 12, 31, 1, 0, 0, 0));
		send_request(make_request(OP_ADD, 4000, 6, 15, 65535, 0, 0, 0));
		// Leap handling: into the leap day, past a common February, a leap day that does not
		// exist, and a century year, which is still a leap year here.
		send_request(make_request(OP_ADD, 2024, 2, 28, 1, 0, 0, 0));
		send_request(make_request(OP_ADD, 2023, 2, 28, 1, 0, 0, 0));
		send_request(make_request(OP_ADD, 2023, 2, 29, 0, 0, 0, 0));
		send_request(make_request(OP_ADD, 2100, 2, 29, 0, 0, 0, 0));
		send_request(make_request(OP_ADD, 2024, 1, 31, 30, 0, 0, 0));
		send_request(make_request(OP_ADD, 1, 3, 1, 1461, 0, 0, 0));
		// Invalid first dates: month codes outside the year, day zero, a day past month end.
		send_request(make_request(OP_ADD, 2000, 0, 10, 5, 0, 0, 0));
		send_request(make_request(OP_ADD, 2000, 13, 10, 5, 0, 0, 0));
		send_request(make_request(OP_ADD, 4095, 15, 31, 65535, 0, 0, 0));
		send_request(make_request(OP_ADD, 2000, 5, 0, 5, 0, 0, 0));
		send_request(make_request(OP_ADD, 2000, 4, 31, 5, 0, 0, 0));
		// Differences: equal dates, the widest span, a second date later by a day and by
		// years, invalid dates on either side, and spans across a leap day and a new year.
		send_request(make_request(OP_DIFF, 2024, 2, 29, 0, 2024, 2, 29));
		send_request(make_request(OP_DIFF, 4095, 12, 31, 0, 0, 1, 1));
		send_request(make_request(OP_DIFF, 2024, 3, 1, 0, 2024, 3, 2));
		send_request(make_request(OP_DIFF, 10, 1, 1, 0, 4095, 12, 31));
		send_request(make_request(OP_DIFF, 2024, 3, 1, 0, 2020, 0, 1));
		send_request(make_request(OP_DIFF, 2024, 3, 0, 0, 2020, 1, 1));
		send_request(make_request(OP_DIFF, 2024, 15, 31, 0, 2020, 1, 1));
		send_request(make_request(OP_DIFF, 2024, 3, 1, 0, 2024, 2, 28));
		send_request(make_request(OP_DIFF, 2024, 1, 1, 65535, 2023, 12, 31));
		// The sender waits for the block to empty completely before random traffic starts.
		await_all_results();

		send_random_chunks(12);

		// The receiver holds off for a long stretch while requests keep coming without gaps,
		// so the waiting result blocks the next one and the input stalls.
		sender_odds = 0;
		hold_request = 1'b1;
		repeat (24)
			send_request(random_request());
		await_all_results();

		send_random_chunks(10);

		// Closing stretch: both sides run flat out.
		final_stretch = 1'b1;
		repeat (200)
			send_request(random_request());
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (ledger.results_due.size() != 0)
			@(posedge clk);
		// Further quiet cycles catch any result the block should not have given.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d requests (%0d adds, %0d differences)",
			ledger.adds + ledger.diffs, ledger.adds, ledger.diffs,
			" with %0d long hold(s) and %0d drain(s).", holds_done, drains_done);
		$display("Statuses: %0d ok, %0d invalid date, %0d year overflow, %0d second date later.",
			ledger.status_seen[ST_OK], ledger.status_seen[ST_INVALID],
			ledger.status_seen[ST_OVERFLOW], ledger.status_seen[ST_LATER]);
		if (ledger.mismatches == 0)
			$display("date_add_and_difference regression: pass");
		else
			$display("date_add_and_difference regression: fail");
		$finish;
	end
endmodule
